/* hw/rtl/sda_pkg.sv */
package sda_pkg;

    // Fixed field widths
    localparam int VIEW_W   = 8;
    localparam int TANG_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 18;
    // Neighbour positions reach one beyond the 8-bit range, negated too
    localparam int POS_W    = 10;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_NUM_VIEWS = 2'd0;
    localparam logic [1:0] REG_TANG_LOW  = 2'd1;
    localparam logic [1:0] REG_TANG_HIGH = 2'd2;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_QUERY,
        S_DRAIN,
        S_WAIT
    } t_state;

    // Configuration as seen by the datapath; views already clamped
    typedef struct packed {
        logic [VIEW_W-1:0] views;
        logic [TANG_W-1:0] tang_low;
        logic [6:0]        tang_high;
    } t_cfg;

endpackage

/* hw/rtl/sda_ram.sv */
module sda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sda_fetch.sv */
module sda_fetch #(
    parameter int MAX_VIEWS  = 128,
    parameter int TANG_SLOTS = 256
) (
    input  sda_pkg::t_cfg                               i_cfg,
    input  logic [sda_pkg::VIEW_W-1:0]                  i_view,
    input  logic signed [sda_pkg::POS_W-1:0]            i_pos,
    output logic                                        o_hit,
    output logic                                        o_wrap,
    output logic [$clog2(MAX_VIEWS*TANG_SLOTS)-1:0]     o_addr
);
    import sda_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VIEWS * TANG_SLOTS);
    localparam int SLOT_W = $clog2(TANG_SLOTS);
    localparam int SW     = (SLOT_W + 2 > POS_W) ? SLOT_W + 2 : POS_W;

    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] low_ext;
    logic signed [POS_W-1:0] high_ext;
    logic signed [SW-1:0]    slot;
    logic                    in_range;
    logic                    slot_ok;
    logic [VIEW_W-1:0]       view_mod;

    // Past the last view the sinogram wraps with a mirrored position
    assign o_wrap   = (i_view >= i_cfg.views);
    assign pos      = o_wrap ? -i_pos : i_pos;
    assign low_ext  = {{(POS_W-TANG_W){i_cfg.tang_low[TANG_W-1]}}, i_cfg.tang_low};
    assign high_ext = {{(POS_W-7){1'b0}}, i_cfg.tang_high};
    assign in_range = (pos >= low_ext) && (pos <= high_ext);

    // Store slot of the position
    assign slot    = SW'(pos) + $signed(SW'(TANG_SLOTS / 2));
    assign slot_ok = (slot >= $signed(SW'(0))) && (slot < $signed(SW'(TANG_SLOTS)));

    // Fetch views never exceed the view count, so wrapping lands on view zero
    assign view_mod = o_wrap ? '0 : i_view;

    assign o_hit  = in_range && slot_ok;
    assign o_addr = ADDR_W'(view_mod) * ADDR_W'(TANG_SLOTS)
                  + ADDR_W'(slot[SLOT_W-1:0]);

endmodule

/* hw/rtl/sda_ctrl.sv */
module sda_ctrl #(
    parameter int MAX_VIEWS  = 128,
    parameter int TANG_SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sda_pkg::t_cfg                     i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [sda_pkg::VIEW_W-1:0]        i_view,
    input  logic signed [sda_pkg::TANG_W-1:0] i_tang,
    input  logic [sda_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sda_pkg::VALUE_W-1:0]       o_value_quarters
);
    import sda_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VIEWS * TANG_SLOTS);

    t_state               r_state,     n_state;
    logic [1:0]           r_k,         n_k;
    logic                 r_pend,      n_pend;
    logic                 r_out_valid, n_out_valid;
    logic [VIEW_W-1:0]    r_view,      n_view;
    logic [TANG_W-1:0]    r_tang,      n_tang;
    logic [SAMPLE_W-1:0]  r_sample,    n_sample;
    logic                 r_even,      n_even;
    logic                 r_gate,      n_gate;
    logic [VALUE_W-1:0]   r_acc,       n_acc;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;

    logic [VIEW_W-1:0]       view_half;
    logic [VIEW_W-1:0]       view_half_p1;
    logic [VIEW_W-1:0]       view_up;
    logic [VIEW_W:0]         view_inc;
    logic signed [POS_W-1:0] tang_ext;
    logic [VIEW_W-1:0]       f_view;
    logic signed [POS_W-1:0] f_pos;
    logic                    f_hit;
    logic                    f_wrap;
    logic [ADDR_W-1:0]       f_addr;
    logic                    ram_we;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic [VALUE_W-1:0]      addend;
    logic [VALUE_W-1:0]      acc_sum;
    logic                    out_free;

    // Neighbour views of the held query
    assign view_half    = {1'b0, r_view[VIEW_W-1:1]};
    assign view_half_p1 = view_half + VIEW_W'(1);
    assign view_inc     = {1'b0, r_view} + (VIEW_W+1)'(1);
    assign view_up      = view_inc[VIEW_W:1];
    assign tang_ext     = {{(POS_W-TANG_W){r_tang[TANG_W-1]}}, r_tang};

    // Operand select for the shared fetch unit
    always_comb begin
        f_view = r_view;
        f_pos  = tang_ext;
        if (r_state == S_QUERY) begin
            if (r_even) begin
                f_view = view_up;
                f_pos  = tang_ext;
            end else begin
                case (r_k)
                    2'd0: begin
                        f_view = view_half;
                        f_pos  = tang_ext;
                    end
                    2'd1: begin
                        f_view = view_half_p1;
                        f_pos  = tang_ext;
                    end
                    2'd2: begin
                        f_view = view_up;
                        f_pos  = tang_ext - POS_W'(1);
                    end
                    2'd3: begin
                        f_view = view_up;
                        f_pos  = tang_ext + POS_W'(1);
                    end
                    default: begin
                        f_view = r_view;
                        f_pos  = tang_ext;
                    end
                endcase
            end
        end
    end

    sda_fetch #(
        .MAX_VIEWS  (MAX_VIEWS),
        .TANG_SLOTS (TANG_SLOTS)
    ) u_fetch (
        .i_cfg  (i_cfg),
        .i_view (f_view),
        .i_pos  (f_pos),
        .o_hit  (f_hit),
        .o_wrap (f_wrap),
        .o_addr (f_addr)
    );

    sda_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_VIEWS * TANG_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (f_addr),
        .i_wdata (r_sample),
        .o_rdata (ram_rdata)
    );

    // Read data arrives in the cycle after its address; even bins count four times
    assign addend   = !r_pend ? '0
                    : (r_even ? {ram_rdata, 2'b00} : {2'b00, ram_rdata});
    assign acc_sum  = r_acc + addend;
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_view      = r_view;
        n_tang      = r_tang;
        n_sample    = r_sample;
        n_even      = r_even;
        n_gate      = r_gate;
        n_acc       = r_acc;
        n_out_value = r_out_value;
        ram_we      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_view   = i_view;
                    n_tang   = i_tang;
                    n_sample = i_sample;
                    n_acc    = '0;
                    n_k      = 2'd0;
                    n_even   = ~(i_view[0] ^ i_tang[0]);
                    // Bins off the tangential edges or past the last view give zero
                    n_gate   = ({1'b0, i_view} < {i_cfg.views, 1'b0})
                            && (i_tang > $signed(i_cfg.tang_low))
                            && (i_tang < $signed({1'b0, i_cfg.tang_high}));
                    n_state  = (i_mode == MODE_QUERY) ? S_QUERY : S_LOAD;
                end
            end
            S_LOAD: begin
                ram_we  = f_hit && !f_wrap;
                n_state = S_IDLE;
            end
            S_QUERY: begin
                n_pend = r_gate && f_hit;
                n_acc  = acc_sum;
                n_k    = r_k + 2'd1;
                if (r_even || (r_k == 2'd3)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = acc_sum;
                    n_state     = S_IDLE;
                end else begin
                    n_acc   = acc_sum;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_view      <= n_view;
        r_tang      <= n_tang;
        r_sample    <= n_sample;
        r_even      <= n_even;
        r_gate      <= n_gate;
        r_acc       <= n_acc;
        r_out_value <= n_out_value;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_value_quarters = r_out_value;

endmodule

/* hw/rtl/sinogram_deinterleave_averager.sv */
// Channel   Handshake                       Payload
// in        i_in_valid / o_in_stall         i_mode, i_view, i_tang, i_sample
// out       o_out_valid / i_out_stall       o_value_quarters
// config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One item at a time; the single-port sample memory sets the pace. A load is
// accepted and then written. A query is accepted, issues its reads (one for
// an even bin, four for an odd bin) and then drains the last read into the sum.
// Reset is synchronous; the sample memory is not cleared and must be loaded
// before it is queried. A result waits in the output register while the
// next item is taken; a query finishing into a full output register holds.
module sinogram_deinterleave_averager #(
    parameter int MAX_VIEWS  = 128,
    parameter int TANG_SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [sda_pkg::VIEW_W-1:0]        i_view,
    input  logic signed [sda_pkg::TANG_W-1:0] i_tang,
    input  logic [sda_pkg::SAMPLE_W-1:0]      i_sample,
    // Result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sda_pkg::VALUE_W-1:0]       o_value_quarters
);
    import sda_pkg::*;

    logic [VIEW_W-1:0] r_num_views, n_num_views;
    logic [TANG_W-1:0] r_tang_low,  n_tang_low;
    logic [6:0]        r_tang_high, n_tang_high;
    logic              cfg_write;
    logic [VIEW_W-1:0] views_eff;
    t_cfg              cfg;

    // Register writes
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_num_views = r_num_views;
        n_tang_low  = r_tang_low;
        n_tang_high = r_tang_high;
        if (cfg_write) begin
            case (paddr[3:2])
                REG_NUM_VIEWS: n_num_views = pwdata[VIEW_W-1:0];
                REG_TANG_LOW:  n_tang_low  = pwdata[TANG_W-1:0];
                REG_TANG_HIGH: n_tang_high = pwdata[6:0];
                default: begin
                    n_num_views = r_num_views;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_views <= 8'd128;
            r_tang_low  <= 8'h81;
            r_tang_high <= 7'd127;
        end else begin
            r_num_views <= n_num_views;
            r_tang_low  <= n_tang_low;
            r_tang_high <= n_tang_high;
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_NUM_VIEWS: prdata = {24'd0, r_num_views};
            REG_TANG_LOW:  prdata = {24'd0, r_tang_low};
            REG_TANG_HIGH: prdata = {25'd0, r_tang_high};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // View count clamped to 1 .. MAX_VIEWS
    always_comb begin
        if (r_num_views == '0) begin
            views_eff = VIEW_W'(1);
        end else if (32'(r_num_views) > MAX_VIEWS) begin
            views_eff = VIEW_W'(MAX_VIEWS);
        end else begin
            views_eff = r_num_views;
        end
    end

    assign cfg.views     = views_eff;
    assign cfg.tang_low  = r_tang_low;
    assign cfg.tang_high = r_tang_high;

    sda_ctrl #(
        .MAX_VIEWS  (MAX_VIEWS),
        .TANG_SLOTS (TANG_SLOTS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_view           (i_view),
        .i_tang           (i_tang),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_value_quarters (o_value_quarters)
    );

endmodule

/* tb/sv/sda_checker.sv */
`timescale 1ns / 100ps

// Watches the configuration port and both item channels of the averager,
// keeps its own copy of the sample store and registers, predicts each
// query's bin value and compares results in order.
module sda_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration port, observed
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    // Input channel, observed
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_mode,
    input  logic [7:0]                i_view,
    input  logic signed [7:0]         i_tang,
    input  logic [15:0]               i_sample,
    // Result channel, observed
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [17:0]               i_value_quarters,
    // Status for the testbench top
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int MAX_VIEWS  = 128;
    localparam int TANG_SLOTS = 256;

    // Shadow of the block's store and registers
    logic [15:0]       sample_mem [MAX_VIEWS*TANG_SLOTS];
    logic [7:0]        views_reg;
    logic signed [7:0] low_reg;
    logic [6:0]        high_reg;

    // Bin values still owed by the block, oldest first
    logic [17:0]       quarters_due [$];

    // View count as the datapath uses it: 0 acts as 1, clamp at the store size
    function automatic int views_eff();
        if (views_reg == 8'd0)
            return 1;
        if (int'(views_reg) > MAX_VIEWS)
            return MAX_VIEWS;
        return int'(views_reg);
    endfunction

    // One neighbour: wrapping past the last view mirrors the position
    function automatic logic [15:0] neighbour(int w, int p);
        int n;
        int pos;
        int slot;
        n   = views_eff();
        pos = (w >= n) ? -p : p;
        if (pos < int'(low_reg) || pos > int'(high_reg))
            return 16'd0;
        slot = pos + TANG_SLOTS / 2;
        if (slot < 0 || slot >= TANG_SLOTS)
            return 16'd0;
        return sample_mem[(w % n) * TANG_SLOTS + slot];
    endfunction

    // Output bin in quarter counts: even parity copies, odd parity sums four
    function automatic logic [17:0] bin_quarters(int v, int t);
        logic [19:0] acc;
        acc = '0;
        if (v < 2 * views_eff() && t > int'(low_reg) && t < int'(high_reg)) begin
            if (((v + t) & 1) == 0) begin
                acc = {2'b00, neighbour((v + 1) / 2, t), 2'b00};
            end else begin
                acc = {4'd0, neighbour(v / 2, t)}
                    + {4'd0, neighbour(v / 2 + 1, t)}
                    + {4'd0, neighbour((v + 1) / 2, t - 1)}
                    + {4'd0, neighbour((v + 1) / 2, t + 1)};
            end
        end
        return acc[17:0];
    endfunction

    task automatic flag(input string what, input logic [17:0] want, input logic [17:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        logic [17:0] want;
        if (!i_rst_n) begin
            views_reg = 8'd128;
            low_reg   = -8'sd127;
            high_reg  = 7'd127;
            quarters_due.delete();
        end else begin
            // Register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    sda_pkg::REG_NUM_VIEWS: views_reg = pwdata[7:0];
                    sda_pkg::REG_TANG_LOW:  low_reg   = pwdata[7:0];
                    sda_pkg::REG_TANG_HIGH: high_reg  = pwdata[6:0];
                    default: ;
                endcase
            end

            // Result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (quarters_due.size() == 0) begin
                    flag("result with nothing outstanding", 'x, i_value_quarters);
                end else begin
                    want = quarters_due.pop_front();
                    o_checked++;
                    if (i_value_quarters !== want)
                        flag("value_quarters mismatch", want, i_value_quarters);
                end
            end

            // Input transfer: queries queue a prediction, loads update the store
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == sda_pkg::MODE_QUERY) begin
                    quarters_due.push_back(bin_quarters(int'(i_view), int'(i_tang)));
                end else if (int'(i_view) < views_eff() && int'(i_tang) >= int'(low_reg)
                             && int'(i_tang) <= int'(high_reg)) begin
                    sample_mem[int'(i_view) * TANG_SLOTS + int'(i_tang) + TANG_SLOTS / 2] =
                        i_sample;
                end
            end
        end
        o_pending = quarters_due.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int TANG_SLOTS    = 256;
    localparam int PHASE_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_pat;

    typedef struct {
        int views;
        int low;
        int high;
    } t_setting;

    logic                               i_clk;
    logic                               i_rst_n    = 1'b0;
    logic                               psel       = 1'b0;
    logic                               penable    = 1'b0;
    logic                               pwrite     = 1'b0;
    logic [3:0]                         paddr      = '0;
    logic [31:0]                        pwdata     = '0;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_mode     = sda_pkg::MODE_LOAD;
    logic [sda_pkg::VIEW_W-1:0]         i_view     = '0;
    logic signed [sda_pkg::TANG_W-1:0]  i_tang     = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_sample   = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [sda_pkg::VALUE_W-1:0]        o_value_quarters;

    int fail_count;
    int results_pending;
    int results_checked;
    int cycle_count = 0;

    // Stimulus-side view of the registers and of which store entries hold data
    logic [7:0]        cfg_views = 8'd128;
    logic signed [7:0] cfg_low   = -8'sd127;
    logic [6:0]        cfg_high  = 7'd127;
    bit                written [128*TANG_SLOTS];

    int burst_left = 0;
    int n_queries  = 0;
    int n_loads    = 0;
    int n_settings = 1;
    int phase_items;
    int hold_req   = 0;

    sinogram_deinterleave_averager uut (.*);

    sda_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_view           (i_view),
        .i_tang           (i_tang),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_value_quarters (o_value_quarters),
        .o_fail_count     (fail_count),
        .o_pending        (results_pending),
        .o_checked        (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Stopped after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial begin : receiver
        t_stall_pat pat;
        int pat_left;
        int hold_left;
        int hold_seen;
        int tick;
        pat       = STALL_NONE;
        pat_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        tick      = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (pat_left == 0) begin
                pat      = t_stall_pat'($urandom_range(0, 3));
                pat_left = $urandom_range(32, 400);
            end
            pat_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (pat)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic int views_now();
        if (cfg_views == 8'd0)
            return 1;
        if (int'(cfg_views) > 128)
            return 128;
        return int'(cfg_views);
    endfunction

    // Store entry that a neighbour fetch reads, or -1 when it reads zero
    function automatic int store_addr(int w, int p);
        int n;
        int pos;
        n   = views_now();
        pos = (w >= n) ? -p : p;
        if (pos < int'(cfg_low) || pos > int'(cfg_high))
            return -1;
        return (w % n) * TANG_SLOTS + pos + TANG_SLOTS / 2;
    endfunction

    // Store entry a load writes, or -1 when the block drops it
    function automatic int load_addr(int v, int t);
        if (v < views_now() && t >= int'(cfg_low) && t <= int'(cfg_high))
            return v * TANG_SLOTS + t + TANG_SLOTS / 2;
        return -1;
    endfunction

    function automatic int pick_tang();
        int lo = cfg_low;
        int hi = cfg_high;
        if (lo <= hi)
            return lo + int'($urandom_range(0, hi - lo));
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return 65535;
        return $urandom_range(0, 65535);
    endfunction

    // One input transfer, with bursts and random gaps in between
    task automatic put_item(input logic m, input int v, input int t, input int s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_view     <= v[7:0];
        i_tang     <= t[7:0];
        i_sample   <= s[15:0];
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic put_load(input int v, input int t, input int s);
        int a;
        a = load_addr(v, t);
        if (a >= 0) begin
            written[a] = 1'b1;
            n_loads++;
            phase_items++;
        end
        put_item(sda_pkg::MODE_LOAD, v, t, s);
    endtask

    // Query a bin, first loading any neighbour it reads that holds no data yet.
    // fill < 0 picks random samples for those loads.
    task automatic send_query(input int v, input int t, input int fill);
        int nb [4];
        for (int k = 0; k < 4; k++)
            nb[k] = -1;
        if (v < 2 * views_now() && t > int'(cfg_low) && t < int'(cfg_high)) begin
            if (((v + t) & 1) == 0) begin
                nb[0] = store_addr((v + 1) / 2, t);
            end else begin
                nb[0] = store_addr(v / 2, t);
                nb[1] = store_addr(v / 2 + 1, t);
                nb[2] = store_addr((v + 1) / 2, t - 1);
                nb[3] = store_addr((v + 1) / 2, t + 1);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (nb[k] >= 0 && !written[nb[k]])
                put_load(nb[k] / TANG_SLOTS, nb[k] % TANG_SLOTS - TANG_SLOTS / 2,
                         (fill < 0) ? pick_sample() : fill);
        end
        put_item(sda_pkg::MODE_QUERY, v, t, $urandom_range(0, 65535));
        n_queries++;
        phase_items++;
    endtask

    // Stop offering and let every outstanding result and load complete
    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        case (idx)
            sda_pkg::REG_NUM_VIEWS: cfg_views = val[7:0];
            sda_pkg::REG_TANG_LOW:  cfg_low   = val[7:0];
            sda_pkg::REG_TANG_HIGH: cfg_high  = val[6:0];
            default: ;
        endcase
    endtask

    // Mostly well-formed queries and in-range loads, some noise of either kind
    task automatic random_item();
        int n;
        int r;
        n = views_now();
        r = $urandom_range(0, 99);
        if (r < 55)
            send_query($urandom_range(0, 2 * n - 1), pick_tang(), -1);
        else if (r < 70)
            send_query($urandom_range(0, 255), int'($urandom_range(0, 255)) - 128, -1);
        else if (r < 95)
            put_load($urandom_range(0, n - 1), pick_tang(), pick_sample());
        else
            put_load($urandom_range(0, 255), int'($urandom_range(0, 255)) - 128,
                     pick_sample());
    endtask

    initial begin : stimulus
        t_setting plan [12];
        bit paused;

        plan[0]  = '{128, -128, 127};
        plan[1]  = '{1, -4, 4};
        plan[2]  = '{0, -10, 10};
        plan[3]  = '{255, -20, 20};
        plan[4]  = '{7, -128, 0};
        plan[5]  = '{64, 0, 127};
        plan[6]  = '{3, 5, 3};
        plan[7]  = '{200, 127, 0};
        plan[8]  = '{16, -60, 60};
        plan[9]  = '{128, -127, 127};
        for (int k = 10; k < 12; k++)
            plan[k] = '{$urandom_range(0, 255), int'($urandom_range(0, 160)) - 128,
                        $urandom_range(0, 127)};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset register values
        put_load(0, 0, 65535);
        send_query(0, 0, -1);            // even bin, full scale
        send_query(1, 0, 65535);         // odd bin, four full-scale neighbours
        put_load(5, 10, 0);
        send_query(10, 10, -1);          // zero sample
        send_query(2, 127, -1);          // upper edge
        send_query(2, -127, -1);         // lower edge
        send_query(3, -128, -1);         // beyond the lower edge
        send_query(255, 0, -1);          // neighbours wrap past the last view
        send_query(253, 126, -1);
        put_load(128, 0, 1234);          // view out of range, dropped
        put_load(0, -128, 4321);         // position out of range, dropped
        send_query(1, -126, -1);

        // Directed, few views: wrap with mirrored position, view too large
        settle();
        write_reg(sda_pkg::REG_NUM_VIEWS, 32'd5);
        send_query(10, 0, -1);
        send_query(255, 3, -1);
        send_query(9, 0, -1);
        send_query(9, 1, -1);

        // Random phases, one register setting each
        for (int p = 0; p < 12; p++) begin
            settle();
            write_reg(sda_pkg::REG_NUM_VIEWS, 32'(plan[p].views));
            write_reg(sda_pkg::REG_TANG_LOW,  32'(plan[p].low));
            write_reg(sda_pkg::REG_TANG_HIGH, 32'(plan[p].high));
            n_settings++;
            if (p == 0 || p == 8)
                hold_req++;
            phase_items = 0;
            paused      = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                random_item();
                if (!paused && phase_items >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    settle();
                end
            end
        end

        settle();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d queries and %0d stored samples over %0d register settings",
                 n_queries, n_loads, n_settings);
        $display("%0d results compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
